FILE: rtl/delta_timer_queue_defines.svh
// Assertion macros used by the checker file.
`ifndef DELTA_TIMER_QUEUE_DEFINES_SVH
`define DELTA_TIMER_QUEUE_DEFINES_SVH

// Checked at every edge outside reset.
`define DTQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("delta timer queue check failed");

// Checked at every edge, reset included.
`define DTQ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("delta timer queue check failed during reset");

`endif

FILE: rtl/dtq_pkg.sv
package dtq_pkg;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_TICK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOT_DUE  = 2'd2;

  typedef struct packed {
    op_t         cmd;
    logic [15:0] msg_handle;
    logic [31:0] delay;
    logic [31:0] process_time;
    logic [31:0] tick_diff;
  } in_t;

  typedef struct packed {
    logic        pop_valid;
    logic [15:0] pop_handle;
    logic [1:0]  status;
    logic [6:0]  entry_count;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_WALK_RD,
    S_WALK_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INSERT,
    S_HEAD_RD,
    S_HEAD_CHK
  } state_t;

endpackage

FILE: rtl/dtq_ram.sv
module dtq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/delta_timer_queue.sv
// A push goes from dispatch through the walk (read, compare) over the W entries compared, the
// shift (read, write) over the M entries moved back, and the insert; W + M <= count + 1. Pop
// and tick of a non-empty queue go through dispatch, head read and head check; clear, a full
// push and an empty pop or tick end in dispatch. The RAM gives one registered read and one
// write a cycle; the next command is accepted at the edge that takes the result, and the
// receiver cannot stall it. Synchronous reset empties the queue and sets the sequencer idle.
module delta_timer_queue #(
  parameter int QUEUE_DEPTH = 64,
  parameter int HANDLE_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  dtq_pkg::in_t item,
  output logic         done,
  output dtq_pkg::out_t result
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = HANDLE_BITS + 32;

  dtq_pkg::state_t state, state_next;
  dtq_pkg::in_t    req;
  dtq_pkg::out_t   res_next;
  logic [AW-1:0]   head, head_next;
  logic [CW-1:0]   count, count_next;
  logic [CW-1:0]   idx, idx_next;
  logic [CW-1:0]   pos, pos_next;
  logic [31:0]     remain, remain_next;
  logic            done_next;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [EW-1:0]   wdata, rdata;
  logic [HANDLE_BITS-1:0] rd_handle;
  logic [31:0]     rd_delta;

  assign rd_handle = rdata[EW-1:32];
  assign rd_delta  = rdata[31:0];
  assign busy      = (state != dtq_pkg::S_IDLE);

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(off);
    if (s >= (CW+1)'(QUEUE_DEPTH)) begin
      s = s - (CW+1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  dtq_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dtq_pkg::S_IDLE;
      head  <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req <= item;
    end
    idx    <= idx_next;
    pos    <= pos_next;
    remain <= remain_next;
    if (done_next) begin
      result <= res_next;
    end
  end

  always_comb begin
    state_next  = state;
    head_next   = head;
    count_next  = count;
    idx_next    = idx;
    pos_next    = pos;
    remain_next = remain;
    done_next   = 1'b0;
    res_next    = '0;
    we          = 1'b0;
    waddr       = phys(head, pos);
    wdata       = {rd_handle, rd_delta};
    raddr       = phys(head, idx);

    case (state)
      dtq_pkg::S_IDLE: begin
        if (start) begin
          state_next = dtq_pkg::S_DISPATCH;
        end
      end

      dtq_pkg::S_DISPATCH: begin
        idx_next    = '0;
        remain_next = req.delay;
        case (req.cmd)
          dtq_pkg::OP_PUSH: begin
            if (count == CW'(QUEUE_DEPTH)) begin
              res_next.status = dtq_pkg::ST_FULL;
              done_next       = 1'b1;
              state_next      = dtq_pkg::S_IDLE;
            end else if (count == '0) begin
              pos_next   = '0;
              state_next = dtq_pkg::S_INSERT;
            end else begin
              state_next = dtq_pkg::S_WALK_RD;
            end
          end
          dtq_pkg::OP_POP, dtq_pkg::OP_TICK: begin
            if (count == '0) begin
              res_next.status = (req.cmd == dtq_pkg::OP_POP) ? dtq_pkg::ST_NOT_DUE
                                                             : dtq_pkg::ST_OK;
              done_next       = 1'b1;
              state_next      = dtq_pkg::S_IDLE;
            end else begin
              state_next = dtq_pkg::S_HEAD_RD;
            end
          end
          default: begin
            count_next = '0;
            done_next  = 1'b1;
            state_next = dtq_pkg::S_IDLE;
          end
        endcase
        res_next.entry_count = 7'(count_next);
      end

      dtq_pkg::S_WALK_RD: begin
        state_next = dtq_pkg::S_WALK_CHK;
      end

      dtq_pkg::S_WALK_CHK: begin
        if (rd_delta > remain) begin
          // Insertion point found: this entry keeps only the excess delay.
          we         = 1'b1;
          waddr      = phys(head, idx);
          wdata      = {rd_handle, rd_delta - remain};
          pos_next   = idx;
          idx_next   = count;
          state_next = dtq_pkg::S_SHIFT_RD;
        end else begin
          remain_next = remain - rd_delta;
          idx_next    = idx + 1'b1;
          if (idx + 1'b1 == count) begin
            pos_next   = count;
            state_next = dtq_pkg::S_INSERT;
          end else begin
            state_next = dtq_pkg::S_WALK_RD;
          end
        end
      end

      dtq_pkg::S_SHIFT_RD: begin
        raddr      = phys(head, idx - 1'b1);
        state_next = dtq_pkg::S_SHIFT_WR;
      end

      dtq_pkg::S_SHIFT_WR: begin
        we       = 1'b1;
        waddr    = phys(head, idx);
        idx_next = idx - 1'b1;
        if (idx - 1'b1 == pos) begin
          state_next = dtq_pkg::S_INSERT;
        end else begin
          state_next = dtq_pkg::S_SHIFT_RD;
        end
      end

      dtq_pkg::S_INSERT: begin
        we                   = 1'b1;
        waddr                = phys(head, pos);
        wdata                = {HANDLE_BITS'(req.msg_handle), remain};
        count_next           = count + 1'b1;
        res_next.entry_count = 7'(count_next);
        done_next            = 1'b1;
        state_next           = dtq_pkg::S_IDLE;
      end

      dtq_pkg::S_HEAD_RD: begin
        raddr      = head;
        state_next = dtq_pkg::S_HEAD_CHK;
      end

      dtq_pkg::S_HEAD_CHK: begin
        if (req.cmd == dtq_pkg::OP_POP) begin
          if (rd_delta < req.process_time) begin
            res_next.pop_valid  = 1'b1;
            res_next.pop_handle = 16'(rd_handle);
            head_next           = phys(head, CW'(1));
            count_next          = count - 1'b1;
          end else begin
            res_next.status = dtq_pkg::ST_NOT_DUE;
          end
        end else begin
          we    = 1'b1;
          waddr = head;
          wdata = {rd_handle,
                   (rd_delta > req.tick_diff) ? rd_delta - req.tick_diff : 32'd0};
        end
        res_next.entry_count = 7'(count_next);
        done_next            = 1'b1;
        state_next           = dtq_pkg::S_IDLE;
      end

      default: begin
        state_next = dtq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/dtq_checker.sv
`include "delta_timer_queue_defines.svh"

module dtq_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input dtq_pkg::out_t result
);

  // A result beat only appears once the sequencer is free again.
  `DTQ_ASSERT(a_done_not_busy, done |-> !busy)
  // An accepted command always occupies the block for the next cycle.
  `DTQ_ASSERT(a_accept_busy, (start && !busy) |=> busy)
  // A released handle comes with a clean status.
  `DTQ_ASSERT(a_pop_ok, (done && result.pop_valid) |-> (result.status == dtq_pkg::ST_OK))
  // Reset leaves the block idle with no result beat.
  `DTQ_ASSERT_ALWAYS(a_reset_idle, rst |=> (!busy && !done))

endmodule

bind delta_timer_queue dtq_checker u_dtq_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
